>>> rtl/core/acm_pkg.sv
// shared command and status codes for the aho-corasick matcher
`timescale 1ns / 1ps

package acm_pkg;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_BUILD  = 3'd2;
    localparam logic [2:0] CMD_SETPOS = 3'd3;
    localparam logic [2:0] CMD_MATCH  = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

endpackage

>>> rtl/core/acm_tables.sv
// trie storage: edge, failure link, accept mark and breadth-first queue memories
`timescale 1ns / 1ps

module acm_tables #(
    parameter int ALPHABET  = 26,
    parameter int MAX_NODES = 256
) (
    input  logic                                   aclk,
    // edge memory, one access per cycle
    input  logic                                   e_en,
    input  logic                                   e_we,
    input  logic [$clog2(MAX_NODES)-1:0]           e_node,
    input  logic [$clog2(ALPHABET)-1:0]            e_col,
    input  logic [$clog2(MAX_NODES):0]             e_wdata,
    output logic [$clog2(MAX_NODES):0]             e_rdata,
    // failure links
    input  logic                                   f_en,
    input  logic                                   f_we,
    input  logic [$clog2(MAX_NODES)-1:0]           f_addr,
    input  logic [$clog2(MAX_NODES)-1:0]           f_wdata,
    output logic [$clog2(MAX_NODES)-1:0]           f_rdata,
    // accept marks
    input  logic                                   a_en,
    input  logic                                   a_we,
    input  logic [$clog2(MAX_NODES)-1:0]           a_addr,
    input  logic                                   a_wdata,
    output logic                                   a_rdata,
    // breadth-first queue
    input  logic                                   q_en,
    input  logic                                   q_we,
    input  logic [$clog2(MAX_NODES)-1:0]           q_addr,
    input  logic [$clog2(MAX_NODES)-1:0]           q_wdata,
    output logic [$clog2(MAX_NODES)-1:0]           q_rdata
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int DEPTH = MAX_NODES * ALPHABET;
    localparam int AW    = $clog2(DEPTH);

    logic [NW:0]   edge_mem [DEPTH];
    logic [NW-1:0] fail_mem [MAX_NODES];
    logic          acc_mem  [MAX_NODES];
    logic [NW-1:0] queue_mem[MAX_NODES];

    logic [AW-1:0] e_addr;

    // row base times alphabet plus column
    assign e_addr = AW'(AW'(e_node) * AW'(ALPHABET) + AW'(e_col));

    always_ff @(posedge aclk) begin
        if (e_en) begin
            if (e_we) begin
                edge_mem[e_addr] <= e_wdata;
            end else begin
                e_rdata <= edge_mem[e_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (f_en) begin
            if (f_we) begin
                fail_mem[f_addr] <= f_wdata;
            end else begin
                f_rdata <= fail_mem[f_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            if (a_we) begin
                acc_mem[a_addr] <= a_wdata;
            end else begin
                a_rdata <= acc_mem[a_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_en) begin
            if (q_we) begin
                queue_mem[q_addr] <= q_wdata;
            end else begin
                q_rdata <= queue_mem[q_addr];
            end
        end
    end

endmodule

>>> rtl/core/aho_corasick_matcher_core.sv
// top level of the aho-corasick matcher: command sequencer and stream ports
`timescale 1ns / 1ps

// usage
//  - s_ channel carries commands: s_tuser is the command, s_tdata the symbol
//    and start node, s_tlast flags the last symbol of a pattern on add
//  - m_ channel returns exactly one result transaction per command: the
//    current node, its accept mark, the node count and a status code
//  - one command is in flight at a time; s_tready is high only while idle
//  - every command runs through the single-port memories: add on a new
//    node sweeps the new row, match takes its failure hops one at a time,
//    clear sweeps the root row, and build walks the row of every queued
//    node with the failure hops per edge, then an accept propagation pass
//  - the edge memory port takes one read or write a cycle
//  - reset runs a clearing pass over the root row before the first
//    transaction is taken; no result is produced for it
//  - a stalled receiver holds the result in the output register; the next
//    command is still taken and runs until its own result is ready

module aho_corasick_matcher_core #(
    parameter int ALPHABET  = 26,
    parameter int MAX_NODES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // symbol [7:0], start_node [15:8]
    input  logic [2:0]  s_tuser,   // cmd [2:0]
    input  logic        s_tlast,   // pattern_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // node [7:0], matched [8], node_total [17:9], status [19:18]
);

    import acm_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(ALPHABET);
    localparam int CNW = NW + 1;
    localparam int WW  = (CNW > 8) ? CNW : 8;

    localparam logic [4:0] ST_CLR      = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_DISP     = 5'd2;
    localparam logic [4:0] ST_ADD_CHK  = 5'd3;
    localparam logic [4:0] ST_ADD_SWP  = 5'd4;
    localparam logic [4:0] ST_WALK_RD  = 5'd5;
    localparam logic [4:0] ST_WALK_CHK = 5'd6;
    localparam logic [4:0] ST_WALK_FL  = 5'd7;
    localparam logic [4:0] ST_B_POP    = 5'd8;
    localparam logic [4:0] ST_B_CUR    = 5'd9;
    localparam logic [4:0] ST_B_E      = 5'd10;
    localparam logic [4:0] ST_B_EC     = 5'd11;
    localparam logic [4:0] ST_B_F0     = 5'd12;
    localparam logic [4:0] ST_A_Q      = 5'd13;
    localparam logic [4:0] ST_A_F      = 5'd14;
    localparam logic [4:0] ST_A_A      = 5'd15;
    localparam logic [4:0] ST_A_W      = 5'd16;
    localparam logic [4:0] ST_FIN_RD   = 5'd17;
    localparam logic [4:0] ST_FIN_OUT  = 5'd18;

    // control state
    logic [4:0]     state_reg, state_next;
    logic           emit_reg, emit_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [CNW-1:0] ncount_reg, ncount_next;
    logic [NW-1:0]  cursor_reg, cursor_next;
    logic [NW-1:0]  pos_reg, pos_next;
    logic           m_tvalid_reg, m_tvalid_next;

    // working registers
    logic [2:0]     cmd_reg, cmd_next;
    logic [7:0]     sym_reg, sym_next;
    logic           pend_reg, pend_next;
    logic [7:0]     start_reg, start_next;
    logic [1:0]     status_reg, status_next;
    logic [NW-1:0]  walk_reg, walk_next;
    logic [CNW-1:0] steps_reg, steps_next;
    logic [NW-1:0]  cur_reg, cur_next;
    logic [NW-1:0]  child_reg, child_next;
    logic [CNW-1:0] head_reg, head_next;
    logic [CNW-1:0] tail_reg, tail_next;
    logic [23:0]    m_tdata_reg, m_tdata_next;

    // memory ports
    logic          e_en, e_we;
    logic [NW-1:0] e_node;
    logic [CW-1:0] e_col;
    logic [NW:0]   e_wdata, e_rdata;
    logic          f_en, f_we;
    logic [NW-1:0] f_addr, f_wdata, f_rdata;
    logic          a_en, a_we, a_wdata, a_rdata;
    logic [NW-1:0] a_addr;
    logic          q_en, q_we;
    logic [NW-1:0] q_addr, q_wdata, q_rdata;

    logic          e_valid;
    logic [NW-1:0] e_child;
    logic [CW-1:0] sym_col;
    logic          sym_bad;
    logic          col_last;
    logic          is_build;
    logic          out_free;
    logic [NW-1:0] walk_res;
    logic          walk_done;

    acm_tables #(
        .ALPHABET  (ALPHABET),
        .MAX_NODES (MAX_NODES)
    ) u_tables (
        .aclk    (aclk),
        .e_en    (e_en),
        .e_we    (e_we),
        .e_node  (e_node),
        .e_col   (e_col),
        .e_wdata (e_wdata),
        .e_rdata (e_rdata),
        .f_en    (f_en),
        .f_we    (f_we),
        .f_addr  (f_addr),
        .f_wdata (f_wdata),
        .f_rdata (f_rdata),
        .a_en    (a_en),
        .a_we    (a_we),
        .a_addr  (a_addr),
        .a_wdata (a_wdata),
        .a_rdata (a_rdata),
        .q_en    (q_en),
        .q_we    (q_we),
        .q_addr  (q_addr),
        .q_wdata (q_wdata),
        .q_rdata (q_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign e_valid  = e_rdata[NW];
    assign e_child  = e_rdata[NW-1:0];
    assign sym_col  = sym_reg[CW-1:0];
    assign sym_bad  = ({1'b0, sym_reg} >= 9'(ALPHABET));
    assign col_last = (col_reg == CW'(ALPHABET - 1));
    assign is_build = (cmd_reg == CMD_BUILD);
    assign out_free = !m_tvalid_reg || m_tready;

    // outcome of one failure-walk check: edge found, root reached or hop limit hit
    always_comb begin
        walk_done = 1'b1;
        walk_res  = '0;
        if (e_valid) begin
            walk_res = e_child;
        end else if (walk_reg != '0 && steps_reg != CNW'(MAX_NODES)) begin
            walk_done = 1'b0;
        end
        // targets beyond the nodes in use, or during build a link back to the node itself, fall to root
        if (CNW'(walk_res) >= ncount_reg || (is_build && walk_res == child_reg)) begin
            walk_res = '0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        emit_next     = emit_reg;
        col_next      = col_reg;
        ncount_next   = ncount_reg;
        cursor_next   = cursor_reg;
        pos_next      = pos_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd_next      = cmd_reg;
        sym_next      = sym_reg;
        pend_next     = pend_reg;
        start_next    = start_reg;
        status_next   = status_reg;
        walk_next     = walk_reg;
        steps_next    = steps_reg;
        cur_next      = cur_reg;
        child_next    = child_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        m_tdata_next  = m_tdata_reg;

        e_en = 1'b0; e_we = 1'b0; e_node = '0; e_col = '0; e_wdata = '0;
        f_en = 1'b0; f_we = 1'b0; f_addr = '0; f_wdata = '0;
        a_en = 1'b0; a_we = 1'b0; a_addr = '0; a_wdata = 1'b0;
        q_en = 1'b0; q_we = 1'b0; q_addr = '0; q_wdata = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR: begin
                // invalidate the root row, root never accepts
                e_en = 1'b1; e_we = 1'b1; e_node = '0; e_col = col_reg;
                a_en = 1'b1; a_we = 1'b1; a_addr = '0;
                if (col_last) begin
                    col_next   = '0;
                    state_next = emit_reg ? ST_FIN_RD : ST_IDLE;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next    = s_tuser;
                    sym_next    = s_tdata[7:0];
                    start_next  = s_tdata[15:8];
                    pend_next   = s_tlast;
                    status_next = STAT_OK;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP: begin
                state_next = ST_FIN_RD;
                unique case (cmd_reg)
                    CMD_CLEAR: begin
                        ncount_next = CNW'(1);
                        cursor_next = '0;
                        pos_next    = '0;
                        col_next    = '0;
                        emit_next   = 1'b1;
                        state_next  = ST_CLR;
                    end
                    CMD_ADD: begin
                        if (sym_bad) begin
                            status_next = STAT_RANGE;
                        end else begin
                            e_en = 1'b1; e_node = cursor_reg; e_col = sym_col;
                            state_next = ST_ADD_CHK;
                        end
                    end
                    CMD_BUILD: begin
                        f_en = 1'b1; f_we = 1'b1; f_addr = '0;
                        q_en = 1'b1; q_we = 1'b1; q_addr = '0;
                        head_next  = '0;
                        tail_next  = CNW'(1);
                        state_next = ST_B_POP;
                    end
                    CMD_SETPOS: begin
                        if (WW'(start_reg) >= WW'(ncount_reg)) begin
                            status_next = STAT_RANGE;
                        end else begin
                            pos_next = NW'(start_reg);
                        end
                    end
                    CMD_MATCH: begin
                        if (sym_bad) begin
                            status_next = STAT_RANGE;
                        end else begin
                            walk_next  = pos_reg;
                            steps_next = '0;
                            state_next = ST_WALK_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_ADD_CHK: begin
                state_next = ST_FIN_RD;
                if (e_valid) begin
                    if (pend_reg) begin
                        a_en = 1'b1; a_we = 1'b1; a_addr = e_child; a_wdata = 1'b1;
                        cursor_next = '0;
                    end else begin
                        cursor_next = e_child;
                    end
                end else if (ncount_reg >= CNW'(MAX_NODES)) begin
                    status_next = STAT_FULL;
                end else begin
                    // new node takes the next free slot, its row is swept next
                    e_en = 1'b1; e_we = 1'b1; e_node = cursor_reg; e_col = sym_col;
                    e_wdata = {1'b1, NW'(ncount_reg)};
                    f_en = 1'b1; f_we = 1'b1; f_addr = NW'(ncount_reg);
                    a_en = 1'b1; a_we = 1'b1; a_addr = NW'(ncount_reg); a_wdata = pend_reg;
                    cursor_next = pend_reg ? '0 : NW'(ncount_reg);
                    child_next  = NW'(ncount_reg);
                    ncount_next = ncount_reg + 1'b1;
                    col_next    = '0;
                    state_next  = ST_ADD_SWP;
                end
            end
            ST_ADD_SWP: begin
                e_en = 1'b1; e_we = 1'b1; e_node = child_reg; e_col = col_reg;
                if (col_last) begin
                    col_next   = '0;
                    state_next = ST_FIN_RD;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_WALK_RD: begin
                e_en = 1'b1; e_node = walk_reg; e_col = is_build ? col_reg : sym_col;
                state_next = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                if (!walk_done) begin
                    f_en = 1'b1; f_addr = walk_reg;
                    steps_next = steps_reg + 1'b1;
                    state_next = ST_WALK_FL;
                end else if (is_build) begin
                    f_en = 1'b1; f_we = 1'b1; f_addr = child_reg; f_wdata = walk_res;
                    if (col_last) begin
                        col_next   = '0;
                        state_next = ST_B_POP;
                    end else begin
                        col_next   = col_reg + 1'b1;
                        state_next = ST_B_E;
                    end
                end else begin
                    pos_next   = walk_res;
                    state_next = ST_FIN_RD;
                end
            end
            ST_WALK_FL: begin
                walk_next  = f_rdata;
                state_next = ST_WALK_RD;
            end
            ST_B_POP: begin
                if (head_reg < tail_reg) begin
                    q_en = 1'b1; q_addr = head_reg[NW-1:0];
                    head_next  = head_reg + 1'b1;
                    state_next = ST_B_CUR;
                end else begin
                    // accept propagation skips the root at queue slot zero
                    head_next  = CNW'(1);
                    state_next = ST_A_Q;
                end
            end
            ST_B_CUR: begin
                cur_next   = q_rdata;
                col_next   = '0;
                state_next = ST_B_E;
            end
            ST_B_E: begin
                e_en = 1'b1; e_node = cur_reg; e_col = col_reg;
                state_next = ST_B_EC;
            end
            ST_B_EC: begin
                if (!e_valid || CNW'(e_child) >= ncount_reg) begin
                    if (col_last) begin
                        col_next   = '0;
                        state_next = ST_B_POP;
                    end else begin
                        col_next   = col_reg + 1'b1;
                        state_next = ST_B_E;
                    end
                end else begin
                    child_next = e_child;
                    if (tail_reg < CNW'(MAX_NODES)) begin
                        q_en = 1'b1; q_we = 1'b1; q_addr = tail_reg[NW-1:0]; q_wdata = e_child;
                        tail_next = tail_reg + 1'b1;
                    end
                    f_en = 1'b1; f_addr = cur_reg;
                    state_next = ST_B_F0;
                end
            end
            ST_B_F0: begin
                walk_next  = f_rdata;
                steps_next = '0;
                state_next = ST_WALK_RD;
            end
            ST_A_Q: begin
                if (head_reg < tail_reg) begin
                    q_en = 1'b1; q_addr = head_reg[NW-1:0];
                    state_next = ST_A_F;
                end else begin
                    state_next = ST_FIN_RD;
                end
            end
            ST_A_F: begin
                child_next = q_rdata;
                f_en = 1'b1; f_addr = q_rdata;
                state_next = ST_A_A;
            end
            ST_A_A: begin
                a_en = 1'b1; a_addr = f_rdata;
                state_next = ST_A_W;
            end
            ST_A_W: begin
                if (a_rdata) begin
                    a_en = 1'b1; a_we = 1'b1; a_addr = child_reg; a_wdata = 1'b1;
                end
                head_next  = head_reg + 1'b1;
                state_next = ST_A_Q;
            end
            ST_FIN_RD: begin
                a_en = 1'b1; a_addr = pos_reg;
                state_next = ST_FIN_OUT;
            end
            ST_FIN_OUT: begin
                if (out_free) begin
                    m_tdata_next  = {4'd0, status_reg, 9'(ncount_reg), a_rdata, 8'(pos_reg)};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            emit_reg     <= 1'b0;
            col_reg      <= '0;
            ncount_reg   <= CNW'(1);
            cursor_reg   <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            emit_reg     <= emit_next;
            col_reg      <= col_next;
            ncount_reg   <= ncount_next;
            cursor_reg   <= cursor_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        sym_reg     <= sym_next;
        pend_reg    <= pend_next;
        start_reg   <= start_next;
        status_reg  <= status_next;
        walk_reg    <= walk_next;
        steps_reg   <= steps_next;
        cur_reg     <= cur_next;
        child_reg   <= child_next;
        head_reg    <= head_next;
        tail_reg    <= tail_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

>>> tb/sv/acm_scoreboard.sv
// result checker for the aho-corasick matcher: trie predictor and in-order comparison
`timescale 1ns / 1ps

module acm_scoreboard
    import acm_pkg::*;
#(
    parameter int ALPHABET  = 26,
    parameter int MAX_NODES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending_cnt,
    output int          result_cnt,
    output int          match_hits
);

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] node_total;
        logic       matched;
        logic [7:0] node;
    } acm_result_t;

    localparam int EXP_DEPTH = 16;

    // trie image
    logic       edge_ok    [MAX_NODES][ALPHABET];
    int         edge_child [MAX_NODES][ALPHABET];
    int         fail_to    [MAX_NODES];
    logic       accepts    [MAX_NODES];
    int         node_count;
    int         cursor;
    int         position;

    // predictions waiting for their result transaction, oldest at exp_rd
    acm_result_t exp_fifo [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;
    int          exp_level;

    function automatic void clear_trie();
        for (int n = 0; n < MAX_NODES; n++) begin
            fail_to[n] = 0;
            accepts[n] = 1'b0;
            for (int c = 0; c < ALPHABET; c++) begin
                edge_ok[n][c]    = 1'b0;
                edge_child[n][c] = 0;
            end
        end
        node_count = 1;
        cursor     = 0;
        position   = 0;
    endfunction

    // breadth-first failure links, then accept marks along the fail chains
    function automatic void build_links();
        int bfs [MAX_NODES];
        int head, tail, cur, n, f, steps;
        head = 0;
        tail = 1;
        bfs[0] = 0;
        fail_to[0] = 0;
        while (head < tail) begin
            cur = bfs[head];
            head++;
            for (int c = 0; c < ALPHABET; c++) begin
                if (!edge_ok[cur][c]) continue;
                n = edge_child[cur][c];
                if (n >= node_count) continue;
                if (tail < MAX_NODES) begin
                    bfs[tail] = n;
                    tail++;
                end
                f = fail_to[cur];
                steps = 0;
                while (f != 0 && !edge_ok[f][c] && steps < MAX_NODES) begin
                    f = fail_to[f];
                    steps++;
                end
                f = edge_ok[f][c] ? edge_child[f][c] : 0;
                if (f == n || f >= node_count) f = 0;
                fail_to[n] = f;
            end
        end
        for (int i = 1; i < tail; i++)
            if (accepts[fail_to[bfs[i]]]) accepts[bfs[i]] = 1'b1;
    endfunction

    function automatic acm_result_t predict_step(logic [2:0] cmd, int sym, logic pend,
                                                 int start);
        acm_result_t r;
        int steps, n;
        r.status = STAT_OK;
        case (cmd)
            CMD_CLEAR: clear_trie();
            CMD_ADD: begin
                if (sym >= ALPHABET) begin
                    r.status = STAT_RANGE;
                end else if (edge_ok[cursor][sym]) begin
                    cursor = edge_child[cursor][sym];
                    if (pend) begin
                        accepts[cursor] = 1'b1;
                        cursor = 0;
                    end
                end else if (node_count >= MAX_NODES) begin
                    r.status = STAT_FULL;
                end else begin
                    n = node_count;
                    node_count++;
                    for (int c = 0; c < ALPHABET; c++) edge_ok[n][c] = 1'b0;
                    fail_to[n] = 0;
                    accepts[n] = 1'b0;
                    edge_ok[cursor][sym]    = 1'b1;
                    edge_child[cursor][sym] = n;
                    cursor = n;
                    if (pend) begin
                        accepts[cursor] = 1'b1;
                        cursor = 0;
                    end
                end
            end
            CMD_BUILD: build_links();
            CMD_SETPOS: begin
                if (start >= node_count) r.status = STAT_RANGE;
                else position = start;
            end
            CMD_MATCH: begin
                if (sym >= ALPHABET) begin
                    r.status = STAT_RANGE;
                end else begin
                    steps = 0;
                    while (position != 0 && !edge_ok[position][sym] && steps < MAX_NODES) begin
                        position = fail_to[position];
                        steps++;
                    end
                    position = edge_ok[position][sym] ? edge_child[position][sym] : 0;
                    if (position >= node_count) position = 0;
                end
            end
            default: ;
        endcase
        r.node       = position[7:0];
        r.matched    = accepts[position];
        r.node_total = node_count[8:0];
        return r;
    endfunction

    initial clear_trie();

    always @(posedge aclk) begin
        acm_result_t got, want;
        if (!aresetn) begin
            clear_trie();
            exp_wr    = 0;
            exp_rd    = 0;
            exp_level = 0;
            fail_count  <= 0;
            result_cnt  <= 0;
            match_hits  <= 0;
            pending_cnt <= 0;
        end else begin
            // result transaction compared against the oldest prediction
            if (m_tvalid && m_tready) begin
                got = acm_result_t'(m_tdata[19:0]);
                result_cnt <= result_cnt + 1;
                if (exp_level == 0) begin
                    $error("result with nothing expected: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = exp_fifo[exp_rd];
                    exp_rd = (exp_rd == EXP_DEPTH - 1) ? 0 : exp_rd + 1;
                    exp_level--;
                    if (got.matched) match_hits <= match_hits + 1;
                    if (got != want || m_tdata[23:20] != 4'd0) begin
                        fail_count <= fail_count + 1;
                        if (got.node != want.node)
                            $error("node expected %0d actual %0d", want.node, got.node);
                        if (got.matched != want.matched)
                            $error("matched expected %0d actual %0d",
                                   want.matched, got.matched);
                        if (got.node_total != want.node_total)
                            $error("node_total expected %0d actual %0d",
                                   want.node_total, got.node_total);
                        if (got.status != want.status)
                            $error("status expected %0d actual %0d",
                                   want.status, got.status);
                        if (m_tdata[23:20] != 4'd0)
                            $error("pad bits expected 0 actual %h", m_tdata[23:20]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (exp_level == EXP_DEPTH) begin
                    $error("prediction buffer overflow expected %0d actual %0d",
                           EXP_DEPTH - 1, exp_level);
                end else begin
                    exp_fifo[exp_wr] = predict_step(s_tuser, int'(s_tdata[7:0]), s_tlast,
                                                    int'(s_tdata[15:8]));
                    exp_wr = (exp_wr == EXP_DEPTH - 1) ? 0 : exp_wr + 1;
                    exp_level++;
                end
            end
            pending_cnt <= exp_level;
        end
    end

endmodule

>>> tb/sv/tb_aho_corasick_matcher_core.sv
// testbench top for the aho-corasick matcher: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps

module tb_aho_corasick_matcher_core;
    import acm_pkg::*;

    localparam int ALPHABET   = 26;
    localparam int MAX_NODES  = 256;
    localparam int ITEM_GOAL  = 800;
    localparam int IDLE_PCT   = 19;
    // a build over a full table with every failure walk at its hop limit stays well under this
    localparam int STALL_LIMIT = 1000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // symbol [7:0], start_node [15:8]
    logic [2:0]  s_tuser;    // cmd [2:0]
    logic        s_tlast;    // pattern_end
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // node [7:0], matched [8], node_total [17:9], status [19:18]

    int fail_count, pending_cnt, result_cnt, match_hits;
    int items_sent;
    int idle_off;            // when set, neither side idles
    logic hold_off_req;      // asks the receiver process for a long stall
    int full_hits;

    aho_corasick_matcher_core #(
        .ALPHABET (ALPHABET),
        .MAX_NODES(MAX_NODES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    acm_scoreboard #(
        .ALPHABET (ALPHABET),
        .MAX_NODES(MAX_NODES)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending_cnt(pending_cnt),
        .result_cnt (result_cnt),
        .match_hits (match_hits)
    );

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // count full-table statuses for the summary
    always @(posedge aclk) begin
        if (!aresetn) begin
            full_hits <= 0;
        end else if (m_tvalid && m_tready && m_tdata[19:18] == STAT_FULL) begin
            full_hits <= full_hits + 1;
        end
    end

    // watchdog: cycles in which neither channel moves a transaction
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        int held;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                held = 0;
                while (held < 300) begin
                    @(negedge aclk);
                    held++;
                end
                m_tready <= 1'b1;
                wait (!hold_off_req);
            end else if (idle_off) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // one command transaction; inputs move at the falling edge
    task automatic send_cmd(logic [2:0] cmd, logic [7:0] sym, logic pend, logic [7:0] start);
        if (!idle_off) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {start, sym};
        s_tlast  <= pend;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic add_pattern(int len, int sym_hi);
        for (int i = 0; i < len; i++)
            send_cmd(CMD_ADD, 8'($urandom_range(0, sym_hi)), i == len - 1,
                     8'($urandom()));
    endtask

    // hold new commands until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_cnt != 0 || (s_tvalid && s_tready)) @(posedge aclk);
        @(negedge aclk);
    endtask

    // random matches, position sets, bad symbols and unused codes against the current dictionary
    task automatic match_burst(int count, int sym_hi);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                send_cmd(CMD_MATCH, 8'($urandom_range(0, sym_hi)), 1'($urandom()),
                         8'($urandom()));
            else if (pick < 83)
                send_cmd(CMD_SETPOS, 8'($urandom()), 1'($urandom()),
                         8'($urandom_range(0, 20)));
            else if (pick < 88)
                send_cmd(CMD_SETPOS, 8'($urandom()), 1'($urandom()), 8'($urandom()));
            else if (pick < 93)
                send_cmd(CMD_MATCH, 8'($urandom_range(ALPHABET, 255)), 1'($urandom()),
                         8'($urandom()));
            else if (pick < 97)
                send_cmd(3'($urandom_range(5, 7)), 8'($urandom()), 1'($urandom()),
                         8'($urandom()));
            else
                send_cmd(CMD_ADD, 8'($urandom_range(ALPHABET, 255)), 1'($urandom()),
                         8'($urandom()));
        end
    endtask

    initial begin
        int phase;
        int sym_hi;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_CLEAR;
        s_tlast      = 1'b0;
        aresetn      = 1'b0;
        items_sent   = 0;
        idle_off     = 0;
        hold_off_req = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, every command, the error cases
        send_cmd(CMD_MATCH, 8'd0, 1'b0, 8'd0);           // empty trie stays at root
        send_cmd(CMD_ADD, 8'd0, 1'b0, 8'd0);
        send_cmd(CMD_ADD, 8'd25, 1'b1, 8'd0);            // pattern "a z"
        send_cmd(CMD_ADD, 8'd25, 1'b0, 8'd0);
        send_cmd(CMD_ADD, 8'd1, 1'b1, 8'd0);             // pattern "z b"
        send_cmd(CMD_ADD, 8'd25, 1'b1, 8'd0);            // existing edge, marks "z"
        send_cmd(CMD_ADD, 8'd26, 1'b1, 8'd0);            // symbol just past the alphabet
        send_cmd(CMD_ADD, 8'd255, 1'b0, 8'd255);
        send_cmd(CMD_BUILD, 8'd0, 1'b0, 8'd0);
        send_cmd(CMD_SETPOS, 8'd0, 1'b0, 8'd255);        // node out of range
        send_cmd(CMD_SETPOS, 8'd0, 1'b0, 8'd4);          // last node in use
        send_cmd(CMD_SETPOS, 8'd0, 1'b0, 8'd5);          // one past
        send_cmd(CMD_SETPOS, 8'd0, 1'b0, 8'd0);
        send_cmd(CMD_MATCH, 8'd0, 1'b0, 8'd0);
        send_cmd(CMD_MATCH, 8'd25, 1'b0, 8'd0);          // accepting node
        send_cmd(CMD_MATCH, 8'd1, 1'b0, 8'd0);           // failure hop then edge
        send_cmd(CMD_MATCH, 8'd7, 1'b0, 8'd0);           // hop back to root
        send_cmd(CMD_MATCH, 8'd255, 1'b1, 8'd0);         // bad symbol
        send_cmd(3'd5, 8'd3, 1'b1, 8'd1);
        send_cmd(3'd6, 8'd0, 1'b0, 8'd0);
        send_cmd(3'd7, 8'hff, 1'b1, 8'hff);
        send_cmd(CMD_ADD, 8'd2, 1'b1, 8'd0);             // add after build, no rebuild
        send_cmd(CMD_MATCH, 8'd2, 1'b0, 8'd0);
        send_cmd(CMD_CLEAR, 8'd9, 1'b1, 8'd9);
        send_cmd(CMD_MATCH, 8'd0, 1'b0, 8'd0);

        // one table fill to the node limit, under back-pressure
        drain();
        hold_off_req = 1'b1;
        for (int i = 0; i < 20; i++)
            send_cmd(CMD_ADD, 8'($urandom_range(0, ALPHABET - 1)), 1'b0, 8'd0);
        hold_off_req = 1'b0;
        add_pattern(260, ALPHABET - 1);
        send_cmd(CMD_ADD, 8'd3, 1'b1, 8'd0);
        send_cmd(CMD_BUILD, 8'd0, 1'b0, 8'd0);
        match_burst(30, ALPHABET - 1);
        send_cmd(CMD_SETPOS, 8'd0, 1'b0, 8'd255);
        drain();

        // random dictionaries: mostly clear, add, build, match sequences
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            idle_off = (phase == 3);
            sym_hi = ($urandom_range(0, 3) == 0) ? ALPHABET - 1 : $urandom_range(1, 3);
            if ($urandom_range(0, 3) != 0) send_cmd(CMD_CLEAR, 8'($urandom()),
                                                    1'($urandom()), 8'($urandom()));
            for (int p = $urandom_range(1, 5); p > 0; p--)
                add_pattern($urandom_range(1, 6), sym_hi);
            if ($urandom_range(0, 7) != 0)
                send_cmd(CMD_BUILD, 8'($urandom()), 1'($urandom()), 8'($urandom()));
            match_burst($urandom_range(10, 40), sym_hi);
            if (phase % 4 == 1) drain();
            phase++;
        end
        idle_off = 0;

        drain();
        repeat (50) @(posedge aclk);
        $display("run: %0d commands, %0d results checked, %0d accepting, %0d table-full",
                 items_sent, result_cnt, match_hits, full_hits);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
